// ===== rtl/tabo_pkg.sv =====
// Shared types, constants and arithmetic helpers for the tinted alpha blend unit.
`timescale 1ns / 1ps

package tabo_pkg;

    localparam int PIX_W    = 8;
    localparam int FACTOR_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CH_NUM   = 3;
    localparam int STG_NUM  = 10;
    localparam int PROD_W   = 26;
    localparam int DEN_W    = 16;
    localparam int NUM_W    = 24;
    localparam int REM_W    = 25;
    localparam int DVS_W    = 17;
    localparam int DIV_STG  = 3;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_SHADE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 2'd3;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [1:0]       quo;
    } t_div_res;

    // round half up of prod / 65536, saturated to one byte
    function automatic logic [PIX_W-1:0] scale_sat(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0] t;
        t = {1'b0, prod} + 27'd32768;
        if (t[PROD_W:16] > 11'd255) begin
            return 8'hFF;
        end
        return t[23:16];
    endfunction

    // two restoring division steps, quotient bits lsb+1 and lsb
    function automatic t_div_res div_pair(input logic [REM_W-1:0] rem,
                                          input logic [DVS_W-1:0] dvs,
                                          input logic [2:0]       lsb);
        t_div_res         res;
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        r = rem;
        res.quo = 2'b00;
        for (int k = 1; k >= 0; k--) begin
            t = REM_W'(dvs) << (lsb + 3'(k));
            if (r >= t) begin
                r = r - t;
                res.quo[k] = 1'b1;
            end
        end
        res.rem = r;
        return res;
    endfunction

endpackage

// ===== rtl/tinted_alpha_blend_over_unit.sv =====
// Tinted Porter-Duff over blend of one RGBA8 texel onto one RGBA8 pixel, pipelined.
`timescale 1ns / 1ps

// Takes one source/destination pixel pair per clock while o_stall is low and returns
// one blended word for each accepted pair, in order. The depth is set
// by the color divider: the 8-bit quotient of num/den is resolved two bits per stage
// over four stages, behind six stages of multiply and sum. Empty stages close up
// under an output stall, so up to ten words sit in flight before o_stall rises.
// Shade and tint registers are sampled when a word enters; write them only while
// the pipe is empty. A zero source alpha passes the destination through with
// o_write_enable low.
module tinted_alpha_blend_over_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tabo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tabo_pkg::FACTOR_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tabo_pkg::PIX_W-1:0]     i_src_red,
    input  logic [tabo_pkg::PIX_W-1:0]     i_src_green,
    input  logic [tabo_pkg::PIX_W-1:0]     i_src_blue,
    input  logic [tabo_pkg::PIX_W-1:0]     i_src_alpha,
    input  logic [tabo_pkg::PIX_W-1:0]     i_dst_red,
    input  logic [tabo_pkg::PIX_W-1:0]     i_dst_green,
    input  logic [tabo_pkg::PIX_W-1:0]     i_dst_blue,
    input  logic [tabo_pkg::PIX_W-1:0]     i_dst_alpha,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_write_enable,
    output logic [tabo_pkg::PIX_W-1:0]     o_out_red,
    output logic [tabo_pkg::PIX_W-1:0]     o_out_green,
    output logic [tabo_pkg::PIX_W-1:0]     o_out_blue,
    output logic [tabo_pkg::PIX_W-1:0]     o_out_alpha
);
    import tabo_pkg::*;

    // configuration
    logic [FACTOR_W-1:0] r_shade;
    logic [FACTOR_W-1:0] r_tint [CH_NUM];

    // pipeline control
    logic [STG_NUM-1:0] r_vld;
    logic [STG_NUM-1:0] adv;

    // stage 0: factor products, destination weight
    logic [PIX_W-1:0]  r_s0_src [CH_NUM];
    logic [17:0]       r_s0_st  [CH_NUM];
    logic [PIX_W-1:0]  r_s0_dst [4];
    logic [PIX_W-1:0]  r_s0_sa;
    logic [DEN_W-1:0]  r_s0_daw;
    logic              r_s0_zero;
    // stage 1: scaled products, den, destination terms
    logic [PROD_W-1:0] r_s1_prod  [CH_NUM];
    logic [NUM_W-1:0]  r_s1_dterm [CH_NUM];
    logic [PIX_W-1:0]  r_s1_dst   [4];
    logic [PIX_W-1:0]  r_s1_sa;
    logic [DEN_W-1:0]  r_s1_den;
    logic              r_s1_zero;
    // stage 2: scaled source color
    logic [PIX_W-1:0]  r_s2_sc    [CH_NUM];
    logic [NUM_W-1:0]  r_s2_dterm [CH_NUM];
    logic [PIX_W-1:0]  r_s2_dst   [4];
    logic [PIX_W-1:0]  r_s2_sa;
    logic [DEN_W-1:0]  r_s2_den;
    logic              r_s2_zero;
    // stage 3: sc * sa
    logic [DEN_W-1:0]  r_s3_scsa  [CH_NUM];
    logic [NUM_W-1:0]  r_s3_dterm [CH_NUM];
    logic [PIX_W-1:0]  r_s3_dst   [4];
    logic [DEN_W-1:0]  r_s3_den;
    logic              r_s3_zero;
    // stage 4: numerator
    logic [NUM_W-1:0]  r_s4_num [CH_NUM];
    logic [PIX_W-1:0]  r_s4_dst [4];
    logic [DEN_W-1:0]  r_s4_den;
    logic              r_s4_zero;
    // stage 5: divider operands, alpha dividend
    logic [REM_W-1:0]  r_s5_rem [CH_NUM];
    logic [PIX_W-1:0]  r_s5_dst [4];
    logic [DVS_W-1:0]  r_s5_dvs;
    logic [DEN_W-1:0]  r_s5_y;
    logic              r_s5_zero;
    // stages 6..8: divider
    logic [REM_W-1:0]  r_dr_rem  [DIV_STG][CH_NUM];
    logic [PIX_W-1:0]  r_dr_quo  [DIV_STG][CH_NUM];
    logic [PIX_W-1:0]  r_dr_dst  [DIV_STG][4];
    logic [DVS_W-1:0]  r_dr_dvs  [DIV_STG];
    logic              r_dr_zero [DIV_STG];
    // alpha by reciprocal with one correction
    logic [DEN_W-1:0]  r_s6_y;
    logic [PIX_W-1:0]  r_s6_q0;
    logic [PIX_W-1:0]  r_s7_alpha;
    logic [PIX_W-1:0]  r_s8_alpha;
    // stage 9: output word
    logic              r_out_we;
    logic [PIX_W-1:0]  r_out_col [CH_NUM];
    logic [PIX_W-1:0]  r_out_alpha;

    t_div_res          n_div [DIV_STG+1][CH_NUM];
    logic [NUM_W-1:0]  n_q0_sum;
    logic [DEN_W-1:0]  n_alpha_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shade <= FACTOR_ONE;
            for (int c = 0; c < CH_NUM; c++) begin
                r_tint[c] <= FACTOR_ONE;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SHADE:      r_shade   <= i_cfg_data;
                REG_TINT_RED:   r_tint[0] <= i_cfg_data;
                REG_TINT_GREEN: r_tint[1] <= i_cfg_data;
                REG_TINT_BLUE:  r_tint[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        adv[STG_NUM-1] = !r_vld[STG_NUM-1] || !i_stall;
        for (int k = STG_NUM - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STG_NUM; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            n_div[0][c] = div_pair(r_s5_rem[c], r_s5_dvs, 3'd6);
            for (int j = 1; j <= DIV_STG; j++) begin
                n_div[j][c] = div_pair(r_dr_rem[j-1][c], r_dr_dvs[j-1], 3'(6 - 2 * j));
            end
        end
        // y*257 >> 16 never overshoots y/255 and is at most one short
        n_q0_sum    = {r_s5_y, 8'd0} + NUM_W'(r_s5_y);
        n_alpha_rem = r_s6_y - ({r_s6_q0, 8'd0} - DEN_W'(r_s6_q0));
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0_src[0] <= i_src_red;
            r_s0_src[1] <= i_src_green;
            r_s0_src[2] <= i_src_blue;
            r_s0_dst[0] <= i_dst_red;
            r_s0_dst[1] <= i_dst_green;
            r_s0_dst[2] <= i_dst_blue;
            r_s0_dst[3] <= i_dst_alpha;
            r_s0_sa     <= i_src_alpha;
            r_s0_zero   <= (i_src_alpha == '0);
            r_s0_daw    <= DEN_W'(i_dst_alpha) * DEN_W'(8'd255 - i_src_alpha);
            for (int c = 0; c < CH_NUM; c++) begin
                r_s0_st[c] <= 18'(r_shade) * 18'(r_tint[c]);
            end
        end

        if (adv[1]) begin
            for (int c = 0; c < CH_NUM; c++) begin
                r_s1_prod[c]  <= PROD_W'(r_s0_src[c]) * PROD_W'(r_s0_st[c]);
                r_s1_dterm[c] <= NUM_W'(r_s0_dst[c]) * NUM_W'(r_s0_daw);
            end
            r_s1_dst  <= r_s0_dst;
            r_s1_sa   <= r_s0_sa;
            r_s1_den  <= ({r_s0_sa, 8'd0} - DEN_W'(r_s0_sa)) + r_s0_daw;
            r_s1_zero <= r_s0_zero;
        end

        if (adv[2]) begin
            for (int c = 0; c < CH_NUM; c++) begin
                r_s2_sc[c] <= scale_sat(r_s1_prod[c]);
            end
            r_s2_dterm <= r_s1_dterm;
            r_s2_dst   <= r_s1_dst;
            r_s2_sa    <= r_s1_sa;
            r_s2_den   <= r_s1_den;
            r_s2_zero  <= r_s1_zero;
        end

        if (adv[3]) begin
            for (int c = 0; c < CH_NUM; c++) begin
                r_s3_scsa[c] <= DEN_W'(r_s2_sc[c]) * DEN_W'(r_s2_sa);
            end
            r_s3_dterm <= r_s2_dterm;
            r_s3_dst   <= r_s2_dst;
            r_s3_den   <= r_s2_den;
            r_s3_zero  <= r_s2_zero;
        end

        if (adv[4]) begin
            for (int c = 0; c < CH_NUM; c++) begin
                r_s4_num[c] <= ({r_s3_scsa[c], 8'd0} - NUM_W'(r_s3_scsa[c]))
                               + r_s3_dterm[c];
            end
            r_s4_dst  <= r_s3_dst;
            r_s4_den  <= r_s3_den;
            r_s4_zero <= r_s3_zero;
        end

        // round half up: (2*num + den) / (2*den)
        if (adv[5]) begin
            for (int c = 0; c < CH_NUM; c++) begin
                r_s5_rem[c] <= {r_s4_num[c], 1'b0} + REM_W'(r_s4_den);
            end
            r_s5_dvs  <= {r_s4_den, 1'b0};
            r_s5_y    <= r_s4_den + DEN_W'(127);
            r_s5_dst  <= r_s4_dst;
            r_s5_zero <= r_s4_zero;
        end

        if (adv[6]) begin
            for (int c = 0; c < CH_NUM; c++) begin
                r_dr_rem[0][c] <= n_div[0][c].rem;
                r_dr_quo[0][c] <= {6'd0, n_div[0][c].quo};
            end
            r_dr_dvs[0]  <= r_s5_dvs;
            r_dr_dst[0]  <= r_s5_dst;
            r_dr_zero[0] <= r_s5_zero;
            r_s6_y       <= r_s5_y;
            r_s6_q0      <= n_q0_sum[23:16];
        end

        for (int j = 1; j < DIV_STG; j++) begin
            if (adv[6+j]) begin
                for (int c = 0; c < CH_NUM; c++) begin
                    r_dr_rem[j][c] <= n_div[j][c].rem;
                    r_dr_quo[j][c] <= {r_dr_quo[j-1][c][5:0], n_div[j][c].quo};
                end
                r_dr_dvs[j]  <= r_dr_dvs[j-1];
                r_dr_dst[j]  <= r_dr_dst[j-1];
                r_dr_zero[j] <= r_dr_zero[j-1];
            end
        end

        if (adv[7]) begin
            r_s7_alpha <= (n_alpha_rem >= DEN_W'(255)) ? r_s6_q0 + 8'd1 : r_s6_q0;
        end

        if (adv[8]) begin
            r_s8_alpha <= r_s7_alpha;
        end

        // zero source alpha passes the destination through
        if (adv[9]) begin
            r_out_we <= !r_dr_zero[DIV_STG-1];
            for (int c = 0; c < CH_NUM; c++) begin
                r_out_col[c] <= r_dr_zero[DIV_STG-1] ? r_dr_dst[DIV_STG-1][c]
                              : {r_dr_quo[DIV_STG-1][c][5:0], n_div[DIV_STG][c].quo};
            end
            r_out_alpha <= r_dr_zero[DIV_STG-1] ? r_dr_dst[DIV_STG-1][3] : r_s8_alpha;
        end
    end

    assign o_stall        = !adv[0];
    assign o_valid        = r_vld[STG_NUM-1];
    assign o_write_enable = r_out_we;
    assign o_out_red      = r_out_col[0];
    assign o_out_green    = r_out_col[1];
    assign o_out_blue     = r_out_col[2];
    assign o_out_alpha    = r_out_alpha;

    // input only backs up when every stage holds a word and the sink stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled while pipeline has a hole");

    // nonzero source alpha gives den >= 255
    a_den_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !r_s5_zero) |-> (r_s5_dvs >= DVS_W'(510)))
        else $error("divisor below minimum for a written word");

    a_alpha_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_enable) |-> (o_out_alpha != '0))
        else $error("written word with zero alpha");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("valid bits not cleared by reset");

endmodule

// ===== dv/tb_tinted_alpha_blend_over_unit.sv =====
// Self-checking testbench for the tinted over-blend unit: corners, random pixels, stalls.
`timescale 1ns / 1ps

module tb_tinted_alpha_blend_over_unit;
    import tabo_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 9;
    localparam int PIPE_DEPTH   = 10;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;
    localparam int STALL_LIMIT  = 3000;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [PIX_W-1:0] sr;
        logic [PIX_W-1:0] sg;
        logic [PIX_W-1:0] sb;
        logic [PIX_W-1:0] sa;
        logic [PIX_W-1:0] dr;
        logic [PIX_W-1:0] dg;
        logic [PIX_W-1:0] db;
        logic [PIX_W-1:0] da;
    } t_pixel_pair;

    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] a;
    } t_blended_px;

    class t_over_scoreboard;
        logic [FACTOR_W-1:0] shade;
        logic [FACTOR_W-1:0] tint_r;
        logic [FACTOR_W-1:0] tint_g;
        logic [FACTOR_W-1:0] tint_b;
        t_blended_px         pending_q[$];
        int                  n_pairs;
        int                  n_skipped;
        int                  n_checked;
        int                  n_errors;

        function new();
            shade     = FACTOR_ONE;
            tint_r    = FACTOR_ONE;
            tint_g    = FACTOR_ONE;
            tint_b    = FACTOR_ONE;
            n_pairs   = 0;
            n_skipped = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void set_factor(logic [CFG_IDX_W-1:0] idx, logic [FACTOR_W-1:0] val);
            case (idx)
                REG_SHADE:      shade  = val;
                REG_TINT_RED:   tint_r = val;
                REG_TINT_GREEN: tint_g = val;
                REG_TINT_BLUE:  tint_b = val;
                default: ;
            endcase
        endfunction

        // round half up of c*shade*tint/65536, clipped to a byte
        function logic [PIX_W-1:0] tinted(logic [PIX_W-1:0] c, logic [FACTOR_W-1:0] tint);
            longint unsigned v;
            v = longint'(c) * longint'(shade) * longint'(tint);
            v = (v + 32768) >> 16;
            return (v > 255) ? 8'hFF : v[PIX_W-1:0];
        endfunction

        function logic [PIX_W-1:0] over(logic [PIX_W-1:0] sc, logic [PIX_W-1:0] dc,
                                         logic [PIX_W-1:0] sa, logic [PIX_W-1:0] da,
                                         longint unsigned den);
            longint unsigned num;
            longint unsigned v;
            num = longint'(sc) * longint'(sa) * 255
                + longint'(dc) * longint'(da) * (255 - longint'(sa));
            v = (2 * num + den) / (2 * den);
            return (v > 255) ? 8'hFF : v[PIX_W-1:0];
        endfunction

        function t_blended_px blend(t_pixel_pair p);
            t_blended_px     res;
            longint unsigned den;
            longint unsigned a;
            if (p.sa == '0) begin
                res = '{we: 1'b0, r: p.dr, g: p.dg, b: p.db, a: p.da};
                return res;
            end
            den = longint'(p.sa) * 255 + longint'(p.da) * (255 - longint'(p.sa));
            a   = (2 * den + 255) / 510;
            res.we = 1'b1;
            res.r  = over(tinted(p.sr, tint_r), p.dr, p.sa, p.da, den);
            res.g  = over(tinted(p.sg, tint_g), p.dg, p.sa, p.da, den);
            res.b  = over(tinted(p.sb, tint_b), p.db, p.sa, p.da, den);
            res.a  = (a > 255) ? 8'hFF : a[PIX_W-1:0];
            return res;
        endfunction

        function void note_pair(t_pixel_pair p);
            pending_q.insert(pending_q.size(), blend(p));
            n_pairs++;
            if (p.sa == '0) begin
                n_skipped++;
            end
        endfunction

        function void cmp_field(string name, logic [PIX_W-1:0] exp_v, logic [PIX_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                n_errors++;
            end
        endfunction

        function void check_pixel(t_blended_px got);
            t_blended_px exp_px;
            if (pending_q.size() == 0) begin
                $error("output word with nothing outstanding: we=%0b rgba=%h %h %h %h",
                       got.we, got.r, got.g, got.b, got.a);
                n_errors++;
                return;
            end
            exp_px = pending_q.pop_front();
            n_checked++;
            cmp_field("write_enable", PIX_W'(exp_px.we), PIX_W'(got.we));
            cmp_field("out_red",   exp_px.r, got.r);
            cmp_field("out_green", exp_px.g, got.g);
            cmp_field("out_blue",  exp_px.b, got.b);
            cmp_field("out_alpha", exp_px.a, got.a);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FACTOR_W-1:0]  i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    t_pixel_pair          drive_pair;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_write_enable;
    logic [PIX_W-1:0]     o_out_red;
    logic [PIX_W-1:0]     o_out_green;
    logic [PIX_W-1:0]     o_out_blue;
    logic [PIX_W-1:0]     o_out_alpha;

    t_over_scoreboard sb;
    bit               src_burst;
    bit               sink_burst;
    int               idle_cycles;
    int               n_settings;

    tinted_alpha_blend_over_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_src_red      (drive_pair.sr),
        .i_src_green    (drive_pair.sg),
        .i_src_blue     (drive_pair.sb),
        .i_src_alpha    (drive_pair.sa),
        .i_dst_red      (drive_pair.dr),
        .i_dst_green    (drive_pair.dg),
        .i_dst_blue     (drive_pair.db),
        .i_dst_alpha    (drive_pair.da),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // output side: random stall per word, with stretches of none
    initial begin
        int n;
        int words;
        words = 0;
        i_stall <= 1'b0;
        forever begin
            n = sink_burst ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            words++;
            if (words % 40 == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            sb.check_pixel('{we: o_write_enable, r: o_out_red, g: o_out_green,
                             b: o_out_blue, a: o_out_alpha});
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb_tinted_alpha_blend_over_unit: FAIL");
                $finish;
            end
        end
    end

    task automatic send_pair(input t_pixel_pair p);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        drive_pair <= p;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_pair(p);
    endtask

    // drop valid and let every outstanding word come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_factor(idx, val);
    endtask

    task automatic write_factors(input logic [FACTOR_W-1:0] s, input logic [FACTOR_W-1:0] r,
                                 input logic [FACTOR_W-1:0] g, input logic [FACTOR_W-1:0] b);
        wait_idle();
        write_reg(REG_SHADE, s);
        write_reg(REG_TINT_RED, r);
        write_reg(REG_TINT_GREEN, g);
        write_reg(REG_TINT_BLUE, b);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [FACTOR_W-1:0] pick_factor();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return FACTOR_ONE;
            2:       return '1;
            3:       return FACTOR_W'($urandom_range(0, 256));
            default: return FACTOR_W'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic t_pixel_pair pick_pair();
        t_pixel_pair p;
        p = '{sr: pick_byte(), sg: pick_byte(), sb: pick_byte(), sa: pick_byte(),
              dr: pick_byte(), dg: pick_byte(), db: pick_byte(), da: pick_byte()};
        return p;
    endfunction

    initial begin
        sb          = new();
        src_burst   = 1'b0;
        sink_burst  = 1'b0;
        idle_cycles = 0;
        n_settings  = 1;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_SHADE;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        drive_pair  <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset factors: skip path, opaque, transparent-ish and empty destinations
        send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78});
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        send_pair('{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pair('{8'hFF, 8'h80, 8'h01, 8'h01, 8'h00, 8'h7F, 8'hFF, 8'hFF});
        send_pair('{8'hAA, 8'h55, 8'hAA, 8'h80, 8'h55, 8'hAA, 8'h55, 8'h80});
        send_pair('{8'h55, 8'hAA, 8'h55, 8'h7F, 8'hAA, 8'h55, 8'hAA, 8'h00});
        send_pair('{8'h01, 8'hFE, 8'h80, 8'hFE, 8'hFE, 8'h01, 8'h7F, 8'h01});
        // oversized factors saturate the tinted source
        write_factors('1, '1, '1, '1);
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        send_pair('{8'h80, 8'h40, 8'h01, 8'h80, 8'h20, 8'hC0, 8'hFF, 8'hFF});
        send_pair('{8'h01, 8'h02, 8'h03, 8'h01, 8'hFF, 8'h00, 8'h80, 8'h80});
        // zero shade blacks the source out
        write_factors('0, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE);
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        write_factors(FACTOR_ONE, '0, '1, 9'd128);
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40});
        send_pair('{8'hC8, 8'h64, 8'hFF, 8'hC0, 8'h80, 8'h80, 8'h80, 8'h80});
        send_pair('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hAB, 8'hCD, 8'hEF, 8'h01});

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_factors(pick_factor(), pick_factor(), pick_factor(), pick_factor());
            src_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == N_PHASES / 2 && k == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
                send_pair(pick_pair());
            end
        end

        wait_idle();
        $display("covered %0d pixel pairs (%0d with zero source alpha) over %0d factor settings",
                 sb.n_pairs, sb.n_skipped, n_settings);
        $display("checked %0d output words, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb_tinted_alpha_blend_over_unit: PASS");
        end else begin
            $display("tb_tinted_alpha_blend_over_unit: FAIL");
        end
        $finish;
    end

endmodule
